>>> hdl/frc_dither_packer_unit_defines.svh
// ----------------------------------------------------------------------------
// FRC dither packer assertion macros
// Concurrent assertion wrappers, compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef FRC_DITHER_PACKER_UNIT_DEFINES_SVH
`define FRC_DITHER_PACKER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define FRC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frc assertion failed");
`define FRC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frc assertion failed");
`else
`define FRC_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define FRC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> hdl/frc_dp_pkg.sv
// ----------------------------------------------------------------------------
// FRC dither packer package
// Shared types, constants and helper functions.
// ----------------------------------------------------------------------------
package frc_dp_pkg;

    localparam int BYTES_PER_PACKET  = 60;
    localparam int PACKETS_PER_FRAME = 160;

    localparam logic [5:0] LAST_BYTE   = 6'(BYTES_PER_PACKET - 1);
    localparam logic [7:0] LAST_PACKET = 8'(PACKETS_PER_FRAME - 1);
    localparam logic [2:0] LAST_BIT    = 3'd7;

    localparam logic [31:0] SEED_RESET  = 32'h0123_5678;
    localparam logic [3:0]  PHASE_RESET = 4'h0;
    localparam logic [15:0] PAT7_RESET  = 16'h5554;
    localparam logic [15:0] PAT13_RESET = 16'hF777;

    localparam logic [3:0] LEVEL_SEVEN    = 4'd7;
    localparam logic [3:0] LEVEL_THIRTEEN = 4'd13;

    localparam int QDEPTH = 2;

    localparam int APB_AW = 4;

    typedef enum logic [1:0] {
        REG_SEED  = 2'd0,
        REG_PHASE = 2'd1,
        REG_PAT7  = 2'd2,
        REG_PAT13 = 2'd3
    } t_reg_idx;

    localparam logic [15:0] DITHER_PATTERNS [16] = '{
        16'h0000, 16'h0001, 16'h0101, 16'h0421,
        16'h1111, 16'h2491, 16'h5252, 16'h0000,
        16'h5555, 16'h56AB, 16'h5B5B, 16'h76DB,
        16'h7777, 16'h0000, 16'hFEFF, 16'hFFFF
    };

    typedef struct packed {
        logic [31:0] prng_seed;
        logic [3:0]  frame_phase;
        logic [15:0] pattern_level_seven;
        logic [15:0] pattern_level_thirteen;
    } t_cfg;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_header;
        logic       last_of_packet;
        logic       last_of_frame;
    } t_result;

    function automatic logic [31:0] xorshift32(input logic [31:0] s);
        logic [31:0] x;
        x = s;
        x = x ^ (x << 13);
        x = x ^ (x >> 17);
        x = x ^ (x << 5);
        return x;
    endfunction

    function automatic logic [15:0] level_pattern(input logic [3:0] level,
                                                  input t_cfg cfg);
        logic [15:0] p;
        p = DITHER_PATTERNS[level];
        if (level == LEVEL_SEVEN) p = cfg.pattern_level_seven;
        if (level == LEVEL_THIRTEEN) p = cfg.pattern_level_thirteen;
        return p;
    endfunction

endpackage

>>> hdl/frc_dp_if.sv
// ----------------------------------------------------------------------------
// FRC dither packer stream interfaces
// Pixel input channel and packed byte output channel.
// ----------------------------------------------------------------------------
interface frc_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel;
    logic       start_frame;

    modport source (output valid, output pixel, output start_frame, input ready);
    modport sink   (input valid, input pixel, input start_frame, output ready);
endinterface

interface frc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       is_header;
    logic       last_of_packet;
    logic       last_of_frame;

    modport source (output valid, output out_byte, output is_header,
                    output last_of_packet, output last_of_frame, input ready);
    modport sink   (input valid, input out_byte, input is_header,
                    input last_of_packet, input last_of_frame, output ready);
endinterface

>>> hdl/frc_dither_packer_unit.sv
// ----------------------------------------------------------------------------
// FRC dither packer top level
// Temporal dithering of 8-bit gray pixels into a packed 1-bit packet stream.
// ----------------------------------------------------------------------------
// One pixel is taken per clock cycle. The front end steps the xorshift
// generator and packs the dither bit in the cycle the pixel transfer
// happens; a header or data byte enters a two-entry result queue and is
// offered on the output from its entry. Sustained rate is one pixel per
// cycle while the output side keeps up; the input stalls only when both
// queue entries hold untaken bytes. Configuration writes are picked up by
// the next pixel; a new seed loads at the next frame start.
module frc_dither_packer_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    frc_pix_if.sink                        i_pix,
    frc_byte_if.source                     o_byte,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [frc_dp_pkg::APB_AW-1:0]  paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    frc_dp_pkg::t_cfg    w_cfg;
    frc_dp_pkg::t_result w_push_data;
    logic                w_push;
    logic                w_q_ready;

    frc_dp_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    frc_dp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_pix       (i_pix),
        .i_q_ready   (w_q_ready),
        .o_push      (w_push),
        .o_push_data (w_push_data)
    );

    frc_dp_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .o_ready     (w_q_ready),
        .o_byte      (o_byte)
    );

endmodule

>>> hdl/frc_dp_regs.sv
// ----------------------------------------------------------------------------
// FRC dither packer configuration registers
// APB-style register file: seed, frame phase and two dither patterns.
// ----------------------------------------------------------------------------
module frc_dp_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [frc_dp_pkg::APB_AW-1:0]  paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    output frc_dp_pkg::t_cfg               o_cfg
);

    frc_dp_pkg::t_cfg     r_cfg;
    frc_dp_pkg::t_reg_idx w_idx;
    logic                 w_wr;

    assign w_idx  = frc_dp_pkg::t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prng_seed              <= frc_dp_pkg::SEED_RESET;
            r_cfg.frame_phase            <= frc_dp_pkg::PHASE_RESET;
            r_cfg.pattern_level_seven    <= frc_dp_pkg::PAT7_RESET;
            r_cfg.pattern_level_thirteen <= frc_dp_pkg::PAT13_RESET;
        end else if (w_wr) begin
            case (w_idx)
                frc_dp_pkg::REG_SEED:  r_cfg.prng_seed              <= pwdata;
                frc_dp_pkg::REG_PHASE: r_cfg.frame_phase            <= pwdata[3:0];
                frc_dp_pkg::REG_PAT7:  r_cfg.pattern_level_seven    <= pwdata[15:0];
                frc_dp_pkg::REG_PAT13: r_cfg.pattern_level_thirteen <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            frc_dp_pkg::REG_SEED:  prdata = r_cfg.prng_seed;
            frc_dp_pkg::REG_PHASE: prdata = {28'd0, r_cfg.frame_phase};
            frc_dp_pkg::REG_PAT7:  prdata = {16'd0, r_cfg.pattern_level_seven};
            frc_dp_pkg::REG_PAT13: prdata = {16'd0, r_cfg.pattern_level_thirteen};
            default:               prdata = 32'd0;
        endcase
    end

endmodule

>>> hdl/frc_dp_front.sv
// ----------------------------------------------------------------------------
// FRC dither packer front end
// Accepts pixels, steps the generator, packs dither bits and classifies
// each pixel as header, data byte or no result.
// ----------------------------------------------------------------------------
module frc_dp_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  frc_dp_pkg::t_cfg      i_cfg,
    frc_pix_if.sink               i_pix,
    input  logic                  i_q_ready,
    output logic                  o_push,
    output frc_dp_pkg::t_result   o_push_data
);

    logic [31:0] r_prng,  n_prng;
    logic [6:0]  r_acc,   n_acc;
    logic [2:0]  r_bitc,  n_bitc;
    logic [5:0]  r_bytec, n_bytec;
    logic [7:0]  r_pktc,  n_pktc;

    logic [31:0] w_prng;
    logic [6:0]  w_acc;
    logic [2:0]  w_bitc;
    logic [5:0]  w_bytec;
    logic [7:0]  w_pktc;
    logic [31:0] w_x;
    logic [15:0] w_pat;
    logic [3:0]  w_sel;
    logic        w_bit;
    logic        w_header;
    logic        w_done;
    logic        w_pkt_end;
    logic        w_frm_end;
    logic        w_accept;

    assign i_pix.ready = i_q_ready;
    assign w_accept    = i_pix.valid & i_q_ready;

    always_comb begin
        if (i_pix.start_frame) begin
            w_prng  = i_cfg.prng_seed;
            w_acc   = 7'd0;
            w_bitc  = 3'd0;
            w_bytec = 6'd0;
            w_pktc  = 8'd0;
        end else begin
            w_prng  = r_prng;
            w_acc   = r_acc;
            w_bitc  = r_bitc;
            w_bytec = r_bytec;
            w_pktc  = r_pktc;
        end

        w_x       = frc_dp_pkg::xorshift32(w_prng);
        w_pat     = frc_dp_pkg::level_pattern(i_pix.pixel[7:4], i_cfg);
        w_sel     = i_cfg.frame_phase + w_x[3:0];
        w_bit     = w_pat[w_sel];
        w_header  = (w_bitc == 3'd0) && (w_bytec == 6'd0);
        w_done    = (w_bitc == frc_dp_pkg::LAST_BIT);
        w_pkt_end = (w_bytec >= frc_dp_pkg::LAST_BYTE);
        w_frm_end = w_pkt_end && (w_pktc >= frc_dp_pkg::LAST_PACKET);

        n_prng  = w_x;
        n_acc   = {w_acc[5:0], w_bit};
        n_bitc  = w_bitc + 3'd1;
        n_bytec = w_bytec;
        n_pktc  = w_pktc;
        if (w_done) begin
            n_acc  = 7'd0;
            n_bitc = 3'd0;
            if (w_frm_end) begin
                n_prng  = i_cfg.prng_seed;
                n_bytec = 6'd0;
                n_pktc  = 8'd0;
            end else if (w_pkt_end) begin
                n_bytec = 6'd0;
                n_pktc  = w_pktc + 8'd1;
            end else begin
                n_bytec = w_bytec + 6'd1;
            end
        end

        if (w_header) begin
            o_push_data = '{out_byte: w_pktc, is_header: 1'b1,
                            last_of_packet: 1'b0, last_of_frame: 1'b0};
        end else begin
            o_push_data = '{out_byte: {w_acc, w_bit}, is_header: 1'b0,
                            last_of_packet: w_pkt_end, last_of_frame: w_frm_end};
        end
        o_push = w_accept & (w_header | w_done);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prng  <= frc_dp_pkg::SEED_RESET;
            r_acc   <= 7'd0;
            r_bitc  <= 3'd0;
            r_bytec <= 6'd0;
            r_pktc  <= 8'd0;
        end else if (w_accept) begin
            r_prng  <= n_prng;
            r_acc   <= n_acc;
            r_bitc  <= n_bitc;
            r_bytec <= n_bytec;
            r_pktc  <= n_pktc;
        end
    end

endmodule

>>> hdl/frc_dp_queue.sv
// ----------------------------------------------------------------------------
// FRC dither packer result queue
// Short register queue that drives the byte output channel.
// ----------------------------------------------------------------------------
`include "frc_dither_packer_unit_defines.svh"

module frc_dp_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  frc_dp_pkg::t_result   i_push_data,
    output logic                  o_ready,
    frc_byte_if.source            o_byte
);

    localparam int PW = $clog2(frc_dp_pkg::QDEPTH);
    localparam int CW = $clog2(frc_dp_pkg::QDEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(frc_dp_pkg::QDEPTH);
    localparam logic [PW-1:0] LAST = PW'(frc_dp_pkg::QDEPTH - 1);

    frc_dp_pkg::t_result r_mem [frc_dp_pkg::QDEPTH];
    logic [PW-1:0]       r_wptr, r_rptr;
    logic [CW-1:0]       r_count;
    logic                w_pop;
    frc_dp_pkg::t_result w_head;

    assign o_ready = (r_count != FULL);
    assign w_pop   = o_byte.valid & o_byte.ready;
    assign w_head  = r_mem[r_rptr];

    assign o_byte.valid          = (r_count != '0);
    assign o_byte.out_byte       = w_head.out_byte;
    assign o_byte.is_header      = w_head.is_header;
    assign o_byte.last_of_packet = w_head.last_of_packet;
    assign o_byte.last_of_frame  = w_head.last_of_frame;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == LAST) ? '0 : r_wptr + PW'(1);
            end
            if (w_pop) begin
                r_rptr <= (r_rptr == LAST) ? '0 : r_rptr + PW'(1);
            end
            r_count <= r_count + CW'(i_push) - CW'(w_pop);
        end
    end

    `FRC_ASSERT_SAME(a_no_overflow, i_clk, i_rst_n, i_push, r_count != FULL)
    `FRC_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= FULL)
    `FRC_ASSERT_NEXT(a_drain_last, i_clk, i_rst_n, (r_count == CW'(1)) && w_pop && !i_push, !o_byte.valid)
    `FRC_ASSERT_NEXT(a_push_shows, i_clk, i_rst_n, i_push, o_byte.valid)

endmodule

>>> bench/frc_dither_packer_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// FRC dither packer testbench
// Drives pixels and register writes into the packer and checks every packed
// byte against an in-bench dither and packing predictor, with random stalls
// on both streams, several register settings and one full packet.
// ----------------------------------------------------------------------------
module frc_dither_packer_unit_tb;

    localparam int CLK_HALF      = 5;
    localparam int QUIET_LIMIT   = 1000;
    localparam int SETTLE_CYC    = 4;
    localparam int TAIL_CYC      = 8;
    localparam int PACKET_PIXELS = frc_dp_pkg::BYTES_PER_PACKET * 8;

    localparam logic [15:0] LEVEL_PATTERNS [16] = '{
        16'h0000, 16'h0001, 16'h0101, 16'h0421,
        16'h1111, 16'h2491, 16'h5252, 16'h0000,
        16'h5555, 16'h56AB, 16'h5B5B, 16'h76DB,
        16'h7777, 16'h0000, 16'hFEFF, 16'hFFFF
    };

    typedef struct {
        logic [7:0]          pixel;
        logic                start_frame;
        bit                  pinned;
        frc_dp_pkg::t_result res;
    } t_row;

    localparam frc_dp_pkg::t_result NO_RES = '0;
    localparam frc_dp_pkg::t_result HDR0   = '{8'h00, 1'b1, 1'b0, 1'b0};
    localparam frc_dp_pkg::t_result ONES   = '{8'hFF, 1'b0, 1'b0, 1'b0};
    localparam frc_dp_pkg::t_result ZEROS  = '{8'h00, 1'b0, 1'b0, 1'b0};

    // after reset: header, all-ones byte, all-zeros byte, restarts
    t_row directed_rows [25] = '{
        '{8'hF0, 1'b0, 1'b1, HDR0},  '{8'hFF, 1'b0, 1'b0, NO_RES},
        '{8'hFA, 1'b0, 1'b0, NO_RES}, '{8'hF5, 1'b0, 1'b0, NO_RES},
        '{8'hF0, 1'b0, 1'b0, NO_RES}, '{8'hFF, 1'b0, 1'b0, NO_RES},
        '{8'hF8, 1'b0, 1'b0, NO_RES}, '{8'hF3, 1'b0, 1'b1, ONES},
        '{8'h0F, 1'b0, 1'b0, NO_RES}, '{8'h00, 1'b0, 1'b0, NO_RES},
        '{8'h05, 1'b0, 1'b0, NO_RES}, '{8'h0A, 1'b0, 1'b0, NO_RES},
        '{8'h0F, 1'b0, 1'b0, NO_RES}, '{8'h00, 1'b0, 1'b0, NO_RES},
        '{8'h01, 1'b0, 1'b0, NO_RES}, '{8'h0E, 1'b0, 1'b1, ZEROS},
        '{8'h7A, 1'b1, 1'b1, HDR0},  '{8'hD3, 1'b0, 1'b0, NO_RES},
        '{8'h83, 1'b0, 1'b0, NO_RES}, '{8'h9C, 1'b0, 1'b0, NO_RES},
        '{8'hA1, 1'b0, 1'b0, NO_RES}, '{8'hB6, 1'b1, 1'b1, HDR0},
        '{8'h2E, 1'b0, 1'b0, NO_RES}, '{8'h4B, 1'b0, 1'b0, NO_RES},
        '{8'h6D, 1'b0, 1'b0, NO_RES}
    };

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [frc_dp_pkg::APB_AW-1:0]   paddr;
    logic [31:0]                     pwdata;
    logic [31:0]                     prdata;
    logic                            pready;

    frc_pix_if  pix_ch ();
    frc_byte_if out_ch ();

    frc_dither_packer_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_ch),
        .o_byte  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // register shadow and packer state
    logic [31:0] seed_reg;
    logic [3:0]  phase_reg;
    logic [15:0] pat7_reg;
    logic [15:0] pat13_reg;
    logic [31:0] prng_now;
    logic [6:0]  bit_acc;
    logic [2:0]  bit_cnt;
    logic [5:0]  byte_cnt;
    logic [7:0]  packet_cnt;

    frc_dp_pkg::t_result expected_bytes [$];
    bit                  pin_on;
    frc_dp_pkg::t_result pin_res;
    int                  idle_pct;
    int                  errors;
    int                  quiet_cycles;
    int                  n_pixels;
    int                  n_bytes;
    int                  n_headers;
    int                  n_pkt_ends;
    int                  n_frm_ends;
    int                  n_settings;

    function automatic void frame_restart();
        prng_now   = seed_reg;
        bit_acc    = '0;
        bit_cnt    = '0;
        byte_cnt   = '0;
        packet_cnt = '0;
    endfunction

    function automatic bit dither_step(input logic [7:0] px, input logic sf,
                                       output frc_dp_pkg::t_result res);
        logic [31:0] x;
        logic [15:0] pat;
        logic        dbit;
        logic        pkt_end;
        logic        frm_end;
        bit          got;
        got = 1'b0;
        res = '0;
        if (sf) frame_restart();
        if (bit_cnt == '0 && byte_cnt == '0) begin
            res = '{packet_cnt, 1'b1, 1'b0, 1'b0};
            got = 1'b1;
        end
        x = prng_now;
        x = x ^ (x << 13);
        x = x ^ (x >> 17);
        x = x ^ (x << 5);
        prng_now = x;
        case (px[7:4])
            frc_dp_pkg::LEVEL_SEVEN:    pat = pat7_reg;
            frc_dp_pkg::LEVEL_THIRTEEN: pat = pat13_reg;
            default:                    pat = LEVEL_PATTERNS[px[7:4]];
        endcase
        dbit = pat[4'(phase_reg + x[3:0])];
        if (bit_cnt != 3'd7) begin
            bit_acc = {bit_acc[5:0], dbit};
            bit_cnt = bit_cnt + 3'd1;
            return got;
        end
        pkt_end = (int'(byte_cnt) >= frc_dp_pkg::BYTES_PER_PACKET - 1);
        frm_end = pkt_end && (int'(packet_cnt) >= frc_dp_pkg::PACKETS_PER_FRAME - 1);
        res = '{{bit_acc, dbit}, 1'b0, pkt_end, frm_end};
        bit_acc = '0;
        bit_cnt = '0;
        if (frm_end) begin
            frame_restart();
        end else if (pkt_end) begin
            byte_cnt   = '0;
            packet_cnt = packet_cnt + 8'd1;
        end else begin
            byte_cnt = byte_cnt + 6'd1;
        end
        return 1'b1;
    endfunction

    function automatic logic [7:0] random_pixel();
        case ($urandom_range(0, 9))
            0:       return {frc_dp_pkg::LEVEL_SEVEN, 4'($urandom)};
            1:       return {frc_dp_pkg::LEVEL_THIRTEEN, 4'($urandom)};
            2:       return 8'h00;
            3:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // transfer checks and watchdog
    always @(posedge i_clk) begin
        frc_dp_pkg::t_result pred;
        frc_dp_pkg::t_result act;
        frc_dp_pkg::t_result want;
        bit                  got;
        bit                  moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (pix_ch.valid && pix_ch.ready) begin
                moved = 1'b1;
                n_pixels++;
                got = dither_step(pix_ch.pixel, pix_ch.start_frame, pred);
                if (pin_on) expected_bytes.push_back(pin_res);
                else if (got) expected_bytes.push_back(pred);
            end
            if (out_ch.valid && out_ch.ready) begin
                moved = 1'b1;
                act = '{out_ch.out_byte, out_ch.is_header,
                        out_ch.last_of_packet, out_ch.last_of_frame};
                n_bytes++;
                if (act.is_header) n_headers++;
                if (act.last_of_packet) n_pkt_ends++;
                if (act.last_of_frame) n_frm_ends++;
                if (expected_bytes.size() == 0) begin
                    errors++;
                    $display("%0t: expected no byte, actual byte %02h hdr=%b lp=%b lf=%b",
                             $time, act.out_byte, act.is_header, act.last_of_packet,
                             act.last_of_frame);
                end else begin
                    want = expected_bytes.pop_front();
                    if (act !== want) begin
                        errors++;
                        $display({"%0t: mismatch expected byte=%02h hdr=%b lp=%b lf=%b",
                                  " actual byte=%02h hdr=%b lp=%b lf=%b"}, $time,
                                 want.out_byte, want.is_header, want.last_of_packet,
                                 want.last_of_frame, act.out_byte, act.is_header,
                                 act.last_of_packet, act.last_of_frame);
                    end
                end
            end
            if (moved) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT) begin
                    $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
                    $display("simulation failed");
                    $finish;
                end
            end
        end
    end

    // output back-pressure
    initial begin
        int hold;
        hold = 0;
        out_ch.ready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                hold--;
                out_ch.ready <= 1'b0;
            end else if (idle_pct != 0 && $urandom_range(0, 299) < idle_pct) begin
                hold = $urandom_range(0, 12);
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    task automatic send_pixel(input logic [7:0] px, input logic sf, input bit pinned,
                              input frc_dp_pkg::t_result pres);
        int gap;
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            gap = $urandom_range(1, 13);
            pix_ch.valid       <= 1'b0;
            pix_ch.pixel       <= 8'($urandom);
            pix_ch.start_frame <= 1'($urandom);
            repeat (gap) @(negedge i_clk);
        end
        pix_ch.valid       <= 1'b1;
        pix_ch.pixel       <= px;
        pix_ch.start_frame <= sf;
        pin_on  = pinned;
        pin_res = pres;
        @(posedge i_clk);
        while (!pix_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain();
        pix_ch.valid <= 1'b0;
        pin_on = 1'b0;
        while (expected_bytes.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYC) @(negedge i_clk);
    endtask

    task automatic apb_cycle(input frc_dp_pkg::t_reg_idx idx, input bit wr,
                             input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rdata = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic check_reg(input frc_dp_pkg::t_reg_idx idx);
        logic [31:0] rd;
        logic [31:0] want;
        logic [31:0] mask;
        case (idx)
            frc_dp_pkg::REG_SEED: begin
                want = seed_reg;
                mask = 32'hFFFF_FFFF;
            end
            frc_dp_pkg::REG_PHASE: begin
                want = 32'(phase_reg);
                mask = 32'h0000_000F;
            end
            frc_dp_pkg::REG_PAT7: begin
                want = 32'(pat7_reg);
                mask = 32'h0000_FFFF;
            end
            default: begin
                want = 32'(pat13_reg);
                mask = 32'h0000_FFFF;
            end
        endcase
        apb_cycle(idx, 1'b0, 32'h0, rd);
        if ((rd & mask) !== want) begin
            errors++;
            $display("%0t: register %s readback expected %08h actual %08h", $time,
                     idx.name(), want, rd);
        end
    endtask

    task automatic reg_write(input frc_dp_pkg::t_reg_idx idx, input logic [31:0] val);
        logic [31:0] rd;
        apb_cycle(idx, 1'b1, val, rd);
        case (idx)
            frc_dp_pkg::REG_SEED:  seed_reg  = val;
            frc_dp_pkg::REG_PHASE: phase_reg = val[3:0];
            frc_dp_pkg::REG_PAT7:  pat7_reg  = val[15:0];
            default:               pat13_reg = val[15:0];
        endcase
        check_reg(idx);
    endtask

    task automatic configure(input logic [31:0] seed, input logic [3:0] ph,
                             input logic [15:0] p7, input logic [15:0] p13);
        reg_write(frc_dp_pkg::REG_SEED, seed);
        reg_write(frc_dp_pkg::REG_PHASE, {28'($urandom), ph});
        reg_write(frc_dp_pkg::REG_PAT7, {16'($urandom), p7});
        reg_write(frc_dp_pkg::REG_PAT13, {16'($urandom), p13});
        n_settings++;
    endtask

    task automatic random_burst(input int n_items, input bit open_frame, input int start_pct);
        logic sf;
        for (int k = 0; k < n_items; k++) begin
            sf = (k == 0 && open_frame) || ($urandom_range(0, 99) < start_pct);
            send_pixel(random_pixel(), sf, 1'b0, NO_RES);
        end
        drain();
    endtask

    initial begin
        i_rst_n            = 1'b0;
        pix_ch.valid       = 1'b0;
        pix_ch.pixel       = 8'h00;
        pix_ch.start_frame = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = 32'h0;
        pin_on             = 1'b0;
        pin_res            = NO_RES;
        idle_pct           = 0;
        errors             = 0;
        quiet_cycles       = 0;
        n_pixels           = 0;
        n_bytes            = 0;
        n_headers          = 0;
        n_pkt_ends         = 0;
        n_frm_ends         = 0;
        n_settings         = 1;
        seed_reg           = frc_dp_pkg::SEED_RESET;
        phase_reg          = frc_dp_pkg::PHASE_RESET;
        pat7_reg           = frc_dp_pkg::PAT7_RESET;
        pat13_reg          = frc_dp_pkg::PAT13_RESET;
        frame_restart();

        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        check_reg(frc_dp_pkg::REG_SEED);
        check_reg(frc_dp_pkg::REG_PHASE);
        check_reg(frc_dp_pkg::REG_PAT7);
        check_reg(frc_dp_pkg::REG_PAT13);

        idle_pct = 20;
        foreach (directed_rows[r])
            send_pixel(directed_rows[r].pixel, directed_rows[r].start_frame,
                       directed_rows[r].pinned, directed_rows[r].res);
        drain();

        // zero seed: generator sticks at zero, bit index is the phase alone
        idle_pct = 15;
        configure(32'h0, 4'hF, 16'hFFFF, 16'h0000);
        random_burst(50, 1'b1, 3);

        idle_pct = 30;
        configure(32'hFFFF_FFFF, 4'h0, 16'h0000, 16'hFFFF);
        random_burst(50, 1'b1, 3);

        idle_pct = 0;
        configure($urandom, 4'($urandom), 16'($urandom), 16'($urandom));
        random_burst(50, 1'b1, 3);

        // new seed must not disturb the running generator
        idle_pct = 15;
        reg_write(frc_dp_pkg::REG_SEED, $urandom);
        random_burst(50, 1'b0, 3);

        idle_pct = 30;
        configure($urandom, 4'($urandom_range(1, 14)), 16'($urandom), 16'($urandom));
        random_burst(50, 1'b0, 3);

        // one whole packet and the start of the next
        idle_pct = 10;
        configure($urandom, 4'($urandom), 16'($urandom), 16'($urandom));
        random_burst(PACKET_PIXELS + 16, 1'b1, 0);

        idle_pct = 0;
        configure($urandom, 4'($urandom), 16'($urandom), 16'($urandom));
        random_burst(80, 1'b1, 3);

        while (expected_bytes.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYC) @(posedge i_clk);
        if (expected_bytes.size() != 0) begin
            errors += expected_bytes.size();
            $display("%0t: %0d bytes never arrived", $time, expected_bytes.size());
        end

        $display("covered %0d pixel and %0d byte transfers over %0d register settings",
                 n_pixels, n_bytes, n_settings);
        $display("headers %0d, packet ends %0d, frame ends %0d, errors %0d",
                 n_headers, n_pkt_ends, n_frm_ends, errors);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
